// ===== sv/rwd_pkg.sv =====
// Shared types, constants and latencies for the ray wall distance select unit.
package rwd_pkg;

  // Column tag width default
  localparam int COLUMN_BITS_DEF = 12;
  localparam int COLUMN_W        = 12;

  // Field widths
  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;
  localparam int HEAD_W  = 16;
  localparam int SQ_W    = 49;
  localparam int ROOT_W  = 25;
  localparam int REM_W   = 27;
  localparam int MAG_W   = 18;
  localparam int DIST_W  = 32;

  // Pipeline depths
  localparam int SQD_LAT   = 4;
  localparam int ISQRT_LAT = ROOT_W;
  localparam int COS_LAT   = 11;
  localparam int COS_DLY   = SQD_LAT + ISQRT_LAT - COS_LAT;

  // Phase and polynomial constants
  localparam logic [17:0] RAY_TURN_MUL = 18'd166886;
  localparam logic [16:0] HEAD_DIV_MUL = 17'd93207;
  localparam logic [30:0] HEAD_REM_MUL = 31'd1527099484;
  localparam logic [6:0]  HEAD_DIV    = 7'd90;
  localparam logic [30:0] S1 = 31'd1686629713;
  localparam logic [30:0] S3 = 31'd693598660;
  localparam logic [30:0] S5 = 31'd85569306;
  localparam logic [30:0] S7 = 31'd5026988;
  localparam logic [17:0] S9 = 18'd172271;

  // Control carried with each item
  typedef struct packed {
    logic valid;
    logic side;
  } tag_t;

  // Cosine magnitude and sign
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } cos_t;

endpackage

// ===== sv/rwd_sqdist.sv =====
// Squared distances to both hits, nearer-hit selection.
module rwd_sqdist #(
  parameter int COL_W = rwd_pkg::COLUMN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [COL_W-1:0]                  col_in,
  input  logic signed [rwd_pkg::COORD_W-1:0] px,
  input  logic signed [rwd_pkg::COORD_W-1:0] py,
  input  logic signed [rwd_pkg::COORD_W-1:0] hx,
  input  logic signed [rwd_pkg::COORD_W-1:0] hy,
  input  logic signed [rwd_pkg::COORD_W-1:0] vx,
  input  logic signed [rwd_pkg::COORD_W-1:0] vy,
  output rwd_pkg::tag_t                     tag_out,
  output logic [COL_W-1:0]                  col_out,
  output logic [rwd_pkg::SQ_W-1:0]          sq_out
);
  import rwd_pkg::*;

  logic signed [COORD_W:0] dhx, dhy, dvx, dvy;
  logic [COORD_W:0]        ahx, ahy, avx, avy;
  logic [SQ_W-1:0]         qhx, qhy, qvx, qvy;
  logic [SQ_W-1:0]         sh, sv;
  logic [2:0]              vld;
  logic [COL_W-1:0]        c1, c2, c3;

  // Differences
  assign dhx = (COORD_W+1)'(hx) - (COORD_W+1)'(px);
  assign dhy = (COORD_W+1)'(hy) - (COORD_W+1)'(py);
  assign dvx = (COORD_W+1)'(vx) - (COORD_W+1)'(px);
  assign dvy = (COORD_W+1)'(vy) - (COORD_W+1)'(py);

  // Advance the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      tag_out.valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
      tag_out.valid <= vld[2];
      // stage 1: magnitudes
      ahx <= dhx[COORD_W] ? (COORD_W+1)'(-dhx) : (COORD_W+1)'(dhx);
      ahy <= dhy[COORD_W] ? (COORD_W+1)'(-dhy) : (COORD_W+1)'(dhy);
      avx <= dvx[COORD_W] ? (COORD_W+1)'(-dvx) : (COORD_W+1)'(dvx);
      avy <= dvy[COORD_W] ? (COORD_W+1)'(-dvy) : (COORD_W+1)'(dvy);
      c1  <= col_in;
      // stage 2: squares
      qhx <= SQ_W'(ahx * ahx);
      qhy <= SQ_W'(ahy * ahy);
      qvx <= SQ_W'(avx * avx);
      qvy <= SQ_W'(avy * avy);
      c2  <= c1;
      // stage 3: sums
      sh <= qhx + qhy;
      sv <= qvx + qvy;
      c3 <= c2;
      // stage 4: pick the nearer hit, tie goes vertical
      tag_out.side <= !(sh < sv);
      sq_out       <= (sh < sv) ? sh : sv;
      col_out      <= c3;
    end
  end

endmodule

// ===== sv/rwd_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module rwd_isqrt #(
  parameter int COL_W = rwd_pkg::COLUMN_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  rwd_pkg::tag_t               tag_in,
  input  logic [COL_W-1:0]            col_in,
  input  logic [rwd_pkg::SQ_W-1:0]    sq_in,
  output rwd_pkg::tag_t               tag_out,
  output logic [COL_W-1:0]            col_out,
  output logic [rwd_pkg::ROOT_W-1:0]  root_out
);
  import rwd_pkg::*;

  localparam int N  = ROOT_W;
  localparam int VW = 2 * ROOT_W;

  logic [REM_W-1:0]  rem  [0:N];
  logic [ROOT_W-1:0] root [0:N];
  logic [VW-1:0]     vrest[0:N];
  tag_t              tg   [0:N];
  logic [COL_W-1:0]  cl   [0:N];

  assign rem[0]   = '0;
  assign root[0]  = '0;
  assign vrest[0] = VW'(sq_in);
  assign tg[0]    = tag_in;
  assign cl[0]    = col_in;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    assign rem2  = {rem[i], vrest[i][VW-1 -: 2]};
    assign trial = (REM_W+2)'({root[i], 2'b01});

    // Try the next root bit, keep it if the remainder allows
    always_ff @(posedge clk) begin
      if (rst) begin
        tg[i+1].valid <= 1'b0;
      end else if (en) begin
        tg[i+1] <= tg[i];
        cl[i+1] <= cl[i];
        vrest[i+1] <= {vrest[i][VW-3:0], 2'b00};
        if (rem2 >= trial) begin
          rem[i+1]  <= REM_W'(rem2 - trial);
          root[i+1] <= {root[i][ROOT_W-2:0], 1'b1};
        end else begin
          rem[i+1]  <= REM_W'(rem2);
          root[i+1] <= {root[i][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign tag_out  = tg[N];
  assign col_out  = cl[N];
  assign root_out = root[N];

endmodule

// ===== sv/rwd_cos.sv =====
// Angle difference phase and quarter-wave polynomial cosine.
module rwd_cos (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [rwd_pkg::ANGLE_W-1:0] ang,
  input  logic [rwd_pkg::HEAD_W-1:0]         head,
  output rwd_pkg::cos_t                      cos_out
);
  import rwd_pkg::*;

  logic signed [34:0] rprod;
  logic [32:0]        aprod;
  logic [31:0] rph1, rph2, rph3;
  logic [9:0]  a1, a2, a3;
  logic [15:0] h1;
  logic [6:0]  b2;
  logic [60:0] q3;
  logic [31:0] hph, ph;
  logic [30:0] t4, t5, t6, t7, t8, t9;
  logic [1:0]  quad4;
  logic        n5, n6, n7, n8, n9, n10;
  logic [61:0] tt5;
  logic [30:0] t2_5, t2_6, t2_7, t2_8, t2_9;
  logic [48:0] m6;
  logic [61:0] m7, m8, m9, m10;
  logic [30:0] p7, p8, p9, p10;
  logic [32:0] s11;

  assign rprod = $signed({{19{ang[ANGLE_W-1]}}, ang}) * $signed({17'd0, RAY_TURN_MUL});
  assign aprod = head * HEAD_DIV_MUL;
  assign hph   = 32'({a3, 23'd0}) + 32'(q3[60:37]);
  assign ph    = rph3 - hph + 32'h4000_0000;
  assign t2_5  = tt5[60:30];
  assign p7    = S7 - 31'(m6[48:30]);
  assign p8    = S5 - 31'(m7[61:30]);
  assign p9    = S3 - 31'(m8[61:30]);
  assign p10   = S1 - 31'(m9[61:30]);
  assign s11   = 33'(m10[61:30]) + 33'd8192;

  // Advance the phase and polynomial stages
  always_ff @(posedge clk) begin
    if (en) begin
      // ray phase and heading quotient by 90
      rph1 <= rprod[31:0];
      a1   <= aprod[32:23];
      h1   <= head;
      // heading remainder
      rph2 <= rph1;
      a2   <= a1;
      b2   <= 7'(h1 - 16'(a1 * HEAD_DIV));
      // remainder part of the heading phase, rounded to nearest
      rph3 <= rph2;
      a3   <= a2;
      q3   <= 61'(({b2, 23'd0} + 30'd45) * HEAD_REM_MUL);
      // quadrant fold
      quad4 <= ph[31:30];
      t4    <= ph[30] ? 31'h4000_0000 - 31'(ph[29:0]) : 31'(ph[29:0]);
      // t squared
      t5  <= t4;
      n5  <= quad4[1];
      tt5 <= t4 * t4;
      // Horner chain
      t6 <= t5;  n6 <= n5;  t2_6 <= t2_5;  m6 <= 49'(t2_5 * S9);
      t7 <= t6;  n7 <= n6;  t2_7 <= t2_6;  m7 <= t2_6 * p7;
      t8 <= t7;  n8 <= n7;  t2_8 <= t2_7;  m8 <= t2_7 * p8;
      t9 <= t8;  n9 <= n8;  t2_9 <= t2_8;  m9 <= t2_8 * p9;
      n10 <= n9; m10 <= t9 * p10;
      // round to Q16
      cos_out.mag <= s11[31:14];
      cos_out.neg <= n10;
    end
  end

endmodule

// ===== sv/ray_wall_distance_select_unit.sv =====
// Top level: stream ports, pipeline control and the final distance multiply.
// Throughput: one ray per cycle while the output is taken; the isqrt stages (one root bit each) set the depth.
// A held result stalls the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous) clears every stage valid bit; data registers keep junk.
module ray_wall_distance_select_unit #(
  parameter int COLUMN_BITS = rwd_pkg::COLUMN_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // column[11:0], player_x[35:12], player_y[59:36], horiz_hit_x[83:60],
  // horiz_hit_y[107:84], vert_hit_x[131:108], vert_hit_y[155:132],
  // ray_dir[171:156], heading_deg[187:172], zero pad
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // column_out[11:0], distance[43:12], zero pad
  output logic [47:0]  m_tdata,
  // hit_side[0]
  output logic         m_tuser
);
  import rwd_pkg::*;

  localparam int CW = (COLUMN_BITS < COLUMN_W) ? COLUMN_BITS : COLUMN_W;

  logic              en;
  tag_t              sq_tag, rt_tag;
  logic [CW-1:0]     sq_col, rt_col, p_col;
  logic [SQ_W-1:0]   sq_val;
  logic [ROOT_W-1:0] root;
  cos_t              cos_raw;
  cos_t              cdly [0:COS_DLY];
  tag_t              p_tag;
  logic              p_neg;
  logic [ROOT_W+MAG_W-1:0] prod;
  logic [ROOT_W+MAG_W-1:0] prod_rnd;
  logic [ROOT_W+MAG_W-17:0] dmag;

  // Whole pipe advances unless a result waits
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  rwd_sqdist #(.COL_W(CW)) u_sqdist (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid),
    .col_in(CW'(s_tdata[11:0])),
    .px(s_tdata[35:12]),  .py(s_tdata[59:36]),
    .hx(s_tdata[83:60]),  .hy(s_tdata[107:84]),
    .vx(s_tdata[131:108]), .vy(s_tdata[155:132]),
    .tag_out(sq_tag), .col_out(sq_col), .sq_out(sq_val)
  );

  rwd_isqrt #(.COL_W(CW)) u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .tag_in(sq_tag), .col_in(sq_col), .sq_in(sq_val),
    .tag_out(rt_tag), .col_out(rt_col), .root_out(root)
  );

  rwd_cos u_cos (
    .clk(clk), .en(en),
    .ang(s_tdata[171:156]), .head(s_tdata[187:172]),
    .cos_out(cos_raw)
  );

  // Align the cosine with the root
  assign cdly[0] = cos_raw;
  for (genvar i = 0; i < COS_DLY; i++) begin : g_cdly
    always_ff @(posedge clk) begin
      if (en) begin
        cdly[i+1] <= cdly[i];
      end
    end
  end

  assign prod_rnd = prod + (ROOT_W+MAG_W)'(32768);
  assign dmag     = prod_rnd[ROOT_W+MAG_W-1:16];

  // Multiply, then round, sign and hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag.valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else if (en) begin
      p_tag <= rt_tag;
      p_col <= rt_col;
      p_neg <= cdly[COS_DLY].neg;
      prod  <= root * cdly[COS_DLY].mag;
      m_tvalid <= p_tag.valid;
      m_tuser  <= p_tag.side;
      m_tdata  <= {4'd0,
                   p_neg ? DIST_W'(-DIST_W'(dmag)) : DIST_W'(dmag),
                   COLUMN_W'(p_col)};
    end
  end

`ifndef SYNTHESIS
  a_rst_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    rt_tag.valid |-> cdly[COS_DLY].mag <= MAG_W'(65536))
    else $error("cosine magnitude above one");
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    rt_tag.valid |-> root <= ROOT_W'(23726566))
    else $error("root beyond square root of largest distance");
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[43:38] == 6'd0 || m_tdata[43:38] == 6'h3f))
    else $error("distance beyond reachable range");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> !s_tready || m_tready || m_tvalid)
    else $error("held result dropped");
`endif

endmodule

// ===== verif/tb_ray_wall_distance_select_unit.sv =====
// Testbench for the ray wall distance select unit: directed and random rays checked per transfer.
`timescale 1ns / 1ps

module tb_ray_wall_distance_select_unit;

  localparam logic [31:0] RAY_MUL  = 32'd166886;
  localparam logic [63:0] TURN_HD  = 64'd46080;
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598660;
  localparam logic [63:0] SIN_C5 = 64'd85569306;
  localparam logic [63:0] SIN_C7 = 64'd5026988;
  localparam logic [63:0] SIN_C9 = 64'd172271;

  typedef struct packed {
    logic [15:0] heading_deg;
    logic [15:0] ray_dir;
    logic [23:0] vert_hit_y;
    logic [23:0] vert_hit_x;
    logic [23:0] horiz_hit_y;
    logic [23:0] horiz_hit_x;
    logic [23:0] player_y;
    logic [23:0] player_x;
    logic [11:0] column;
  } ray_t;

  typedef struct packed {
    logic [11:0] column_out;
    logic        hit_side;
    logic [31:0] distance;
  } wall_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic         m_tuser;

  wall_t expected_walls[$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_off = 1'b0;
  int    hold_cycles = 0;

  ray_wall_distance_select_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] sq_span(logic [23:0] a0, logic [23:0] a1,
                                          logic [23:0] b0, logic [23:0] b1);
    longint dx, dy;
    dx = longint'($signed(b0)) - longint'($signed(a0));
    dy = longint'($signed(b1)) - longint'($signed(a1));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return dx * dx + dy * dy;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] quarter_wave(logic [63:0] t);
    logic [63:0] t2, p;
    t2 = (t * t) >> 30;
    p = SIN_C7 - ((t2 * SIN_C9) >> 30);
    p = SIN_C5 - ((t2 * p) >> 30);
    p = SIN_C3 - ((t2 * p) >> 30);
    p = SIN_C1 - ((t2 * p) >> 30);
    return (t * p) >> 30;
  endfunction

  function automatic wall_t predict_wall(ray_t r);
    wall_t w;
    logic [63:0] dh, dv, raw, rem, t, cmag, mag;
    logic [31:0] ray_ph, head_ph, ph;
    logic [1:0]  quad;
    longint      dval;
    dh = sq_span(r.player_x, r.player_y, r.horiz_hit_x, r.horiz_hit_y);
    dv = sq_span(r.player_x, r.player_y, r.vert_hit_x, r.vert_hit_y);
    w.column_out = r.column;
    w.hit_side = (dh < dv) ? 1'b0 : 1'b1;
    raw = floor_root(w.hit_side ? dv : dh);
    ray_ph = 32'(longint'($signed(r.ray_dir)) * longint'(RAY_MUL));
    head_ph = 32'((({48'd0, r.heading_deg} << 32) + TURN_HD / 2) / TURN_HD);
    // shift to cosine, then fold the quadrant onto the first quarter
    ph = ray_ph - head_ph + 32'h4000_0000;
    quad = ph[31:30];
    rem = {34'd0, ph[29:0]};
    t = quad[0] ? (64'd1 << 30) - rem : rem;
    cmag = (quarter_wave(t) + 64'd8192) >> 14;
    mag = (raw * cmag + 64'd32768) >> 16;
    if (quad[1]) dval = (mag > 64'd2147483648) ? -64'sd2147483648 : -longint'(mag);
    else dval = (mag > 64'd2147483647) ? 64'sd2147483647 : longint'(mag);
    w.distance = dval[31:0];
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Drive one ray and hold it until the transfer; valid stays up for a following ray.
  task automatic send_ray(ray_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, r};
    expected_walls.push_back(predict_wall(r));
    do @(posedge clk); while (!s_tready);
  endtask

  // Receiver readiness, with random stalls and long hold-offs.
  always @(posedge clk) begin
    if (hold_off) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    wall_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[11:0], m_tuser, m_tdata[43:12]};
      if (expected_walls.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.column_out), 32'd0);
      end else begin
        want = expected_walls.pop_front();
        if (got.column_out !== want.column_out)
          report_mismatch("column_out", 32'(got.column_out), 32'(want.column_out));
        if (got.hit_side !== want.hit_side)
          report_mismatch("hit_side", 32'(got.hit_side), 32'(want.hit_side));
        if (got.distance !== want.distance)
          report_mismatch("distance", got.distance, want.distance);
      end
    end
  end

  function automatic logic [23:0] near_coord(logic [23:0] base);
    return base + 24'($signed($urandom_range(8191)) - 4096);
  endfunction

  function automatic ray_t random_ray();
    ray_t r;
    r = 188'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(3))
      0: ;
      1: begin
        // nearby hits, plausible scene
        r.horiz_hit_x = near_coord(r.player_x);
        r.horiz_hit_y = near_coord(r.player_y);
        r.vert_hit_x = near_coord(r.player_x);
        r.vert_hit_y = near_coord(r.player_y);
        r.heading_deg = 16'($urandom_range(46079));
      end
      2: begin
        // mirrored hits give equal distances
        r.vert_hit_x = r.player_x - (r.horiz_hit_x - r.player_x);
        r.vert_hit_y = r.horiz_hit_y;
      end
      default: begin
        r.ray_dir = 16'($signed($urandom_range(25736)) - 12868);
        r.heading_deg = 16'($urandom_range(46079));
      end
    endcase
    return r;
  endfunction

  // Drop valid and wait until every expected result has come.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_walls.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    ray_t r;
    int k;
    for (k = 0; k < 20; k++) begin
      r = '0;
      case (k)
        0: ;
        1: begin
          r.column = 12'hFFF;
          r.player_x = 24'h800000; r.player_y = 24'h800000;
          r.horiz_hit_x = 24'h7FFFFF; r.horiz_hit_y = 24'h7FFFFF;
          r.vert_hit_x = 24'h7FFFFF; r.vert_hit_y = 24'h7FFFFF;
        end
        2: begin r.horiz_hit_x = 24'h000100; r.vert_hit_y = 24'h000100; end
        3: begin r.horiz_hit_x = 24'h000100; r.vert_hit_y = 24'h000101; end
        4: begin r.horiz_hit_x = 24'h000101; r.vert_hit_y = 24'h000100; end
        5: begin r.horiz_hit_x = 24'h7FFFFF; r.vert_hit_x = 24'h800000; end
        6: begin r.vert_hit_x = 24'h800000; r.ray_dir = 16'h7FFF; end
        7: begin r.vert_hit_x = 24'h800000; r.ray_dir = 16'h8000; end
        8: begin r.vert_hit_x = 24'h123456; r.heading_deg = 16'd46079; end
        9: begin r.vert_hit_x = 24'h123456; r.heading_deg = 16'hFFFF; end
        10: begin r.vert_hit_x = 24'h123456; r.heading_deg = 16'd11520; end
        11: begin r.vert_hit_x = 24'h123456; r.heading_deg = 16'd23040; end
        12: begin r.vert_hit_x = 24'h123456; r.ray_dir = 16'd6434; end
        13: begin r.vert_hit_x = 24'h123456; r.ray_dir = 16'd12868; end
        14: begin
          r.player_x = 24'h7FFFFF; r.player_y = 24'h7FFFFF;
          r.horiz_hit_x = 24'h800000; r.horiz_hit_y = 24'h800000;
          r.vert_hit_x = 24'h800000; r.vert_hit_y = 24'h7FFFFF;
          r.ray_dir = 16'h8000; r.heading_deg = 16'hFFFF;
        end
        default: r = random_ray();
      endcase
      send_ray(r);
    end
  endtask

  task automatic test_random(int n);
    int k;
    for (k = 0; k < n; k++) send_ray(random_ray());
  endtask

  task automatic test_backpressure();
    int k;
    hold_cycles = 0;
    hold_off = 1'b1;
    // keep offering while output is held; input stalls once the pipe fills
    fork
      for (k = 0; k < 60; k++) send_ray(random_ray());
      begin
        while (hold_cycles < 200) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(420);
    send_idle_pct = 79;
    test_random(420);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 79;
    test_random(420);
    send_idle_pct = 12;
    recv_stall_pct = 12;
    test_random(420);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_walls.size() == 0) begin
      $display("tb_ray_wall_distance_select_unit passed");
    end else begin
      $display("tb_ray_wall_distance_select_unit failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_ray_wall_distance_select_unit failed");
    $finish;
  end

endmodule
